// ===== rtl/core/equirect_to_perspective_remap_core_assert.svh =====
// assertion macros used by the checker file
`ifndef EQUIRECT_TO_PERSPECTIVE_REMAP_CORE_ASSERT_SVH
`define EQUIRECT_TO_PERSPECTIVE_REMAP_CORE_ASSERT_SVH

// clocked property, masked while reset is active
`define E2P_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("e2p assertion failed");

// clocked property that also holds during reset
`define E2P_ASSERT_NORST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("e2p assertion failed");

`endif

// ===== rtl/core/e2p_pkg.sv =====
package e2p_pkg;

	localparam int ANGLE_BITS_DEF    = 20;
	localparam int CORDIC_STAGES_DEF = 20;
	// datapath width of the cordic x/y rails, Q.8 with headroom for gain
	localparam int DATA_W            = 26;
	localparam int GAIN_W            = 30;
	localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032875;

	typedef enum logic [1:0] {
		VIEW_FRONT = 2'd0,
		VIEW_LEFT  = 2'd1,
		VIEW_RIGHT = 2'd2,
		VIEW_STRIP = 2'd3
	} view_t;

	typedef struct packed {
		view_t view;
		logic  err;
	} ctl_t;

	typedef enum logic [2:0] {
		REG_PANO_W  = 3'd0,
		REG_PANO_H  = 3'd1,
		REG_OUT_W   = 3'd2,
		REG_OUT_H   = 3'd3,
		REG_FOCAL   = 3'd4
	} reg_idx_t;

	// atan(2^-i) in turns, 32 fraction bits
	localparam logic [31:0] ATAN_TURN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// table entry rounded to ab fraction bits
	function automatic logic [32:0] table_angle(input int i, input int ab);
		logic [63:0] t;
		int          s;
		t = {32'd0, ATAN_TURN[i[4:0]]};
		s = 32 - ab;
		return 33'((t + ((64'd1 << s) >> 1)) >> s);
	endfunction

endpackage

// ===== rtl/core/equirect_to_perspective_remap_core.sv =====
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined cordic chains
// stalls freeze the whole pipeline together; nothing is dropped or repeated
// reset (arst_n low, asynchronous): all valid bits clear, configuration registers take defaults
module equirect_to_perspective_remap_core #(
	parameter int ANGLE_BITS    = e2p_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = e2p_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // out_col[14:0], out_row[27:15], zero pad
	input  logic [1:0]  s_tuser,  // command[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // src_row[11:0], src_col[24:12], zero pad
	output logic        m_tuser   // range_error
);
	import e2p_pkg::*;

	localparam int AW = ANGLE_BITS + 2;
	localparam int DW = DATA_W;
	localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (ANGLE_BITS - 2);

	// configuration registers
	logic [13:0] pano_w_q;
	logic [12:0] pano_h_q;
	logic [13:0] out_w_q;
	logic [13:0] out_h_q;
	logic [20:0] focal_q;
	logic [2:0]  reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pano_w_q <= 14'd2048;
			pano_h_q <= 13'd1024;
			out_w_q  <= 14'd3000;
			out_h_q  <= 14'd3000;
			focal_q  <= 21'd384000;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_PANO_W: pano_w_q <= pwdata[13:0];
				REG_PANO_H: pano_h_q <= pwdata[12:0];
				REG_OUT_W:  out_w_q  <= pwdata[13:0];
				REG_OUT_H:  out_h_q  <= pwdata[13:0];
				REG_FOCAL:  focal_q  <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PANO_W: prdata = {18'd0, pano_w_q};
			REG_PANO_H: prdata = {19'd0, pano_h_q};
			REG_OUT_W:  prdata = {18'd0, out_w_q};
			REG_OUT_H:  prdata = {18'd0, out_h_q};
			REG_FOCAL:  prdata = {11'd0, focal_q};
			default:    prdata = '0;
		endcase
	end

	// global advance: the pipeline moves whenever the output slot is free or drained
	logic advance;
	logic out_valid;

	assign advance  = !out_valid || m_tready;
	assign s_tready = advance;

	// stage 1: view decode and local column
	logic [14:0] in_col;
	logic [12:0] in_row;
	logic [15:0] col16, w1, w2, w3;
	logic [13:0] lc;
	ctl_t        ctl;

	assign in_col = s_tdata[14:0];
	assign in_row = s_tdata[27:15];
	assign col16  = {1'b0, in_col};
	assign w1     = {2'b00, out_w_q};
	assign w2     = w1 << 1;
	assign w3     = w1 + w2;

	always_comb begin
		lc       = in_col[13:0];
		ctl.view = view_t'(s_tuser);
		ctl.err  = 1'b0;
		if (view_t'(s_tuser) == VIEW_STRIP) begin
			// strip runs left, front, right
			if (col16 < w1) begin
				ctl.view = VIEW_LEFT;
			end else if (col16 < w2) begin
				ctl.view = VIEW_FRONT;
				lc       = 14'(col16 - w1);
			end else if (col16 < w3) begin
				ctl.view = VIEW_RIGHT;
				lc       = 14'(col16 - w2);
			end else begin
				ctl.err  = 1'b1;
			end
		end else begin
			ctl.err = (col16 >= w1);
		end
	end

	logic        v_s1;
	logic [13:0] lc_s1;
	logic [12:0] row_s1;
	ctl_t        ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lc_s1  <= lc;
			row_s1 <= in_row;
			ctl_s1 <= ctl;
		end
	end

	// stage 2: centered coordinates in Q.8
	logic signed [15:0]    xd;
	logic signed [14:0]    zd;
	logic                  v_s2;
	logic signed [DW-1:0]  x_s2, z_s2;
	ctl_t                  ctl_s2;

	assign xd = signed'({2'b00, lc_s1}) - signed'({3'b000, out_w_q[13:1]});
	assign zd = signed'({2'b00, out_h_q[13:1]}) - signed'({2'b00, row_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s2   <= DW'(xd) <<< 8;
			z_s2   <= DW'(zd) <<< 8;
			ctl_s2 <= ctl_s1;
		end
	end

	// first vectoring pass: longitude offset and horizontal magnitude
	localparam int SW1 = DW + $bits(ctl_t);

	logic                 c1_valid;
	logic signed [DW-1:0] c1_x;
	logic signed [AW-1:0] c1_ang;
	logic [SW1-1:0]       c1_side;

	e2p_cordic #(
		.DW (DW),
		.AB (ANGLE_BITS),
		.AW (AW),
		.N  (CORDIC_STAGES),
		.SW (SW1)
	) u_cordic_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (v_s2),
		.in_x      (DW'(signed'({1'b0, focal_q}))),
		.in_y      (x_s2),
		.in_side   ({z_s2, ctl_s2}),
		.out_valid (c1_valid),
		.out_x     (c1_x),
		.out_ang   (c1_ang),
		.out_side  (c1_side)
	);

	// stage 3: gain correction product and longitude
	ctl_t                    c1_ctl;
	logic signed [AW-1:0]    theta;
	logic                    v_s3, err_s3;
	logic [DW+GAIN_W-1:0]    prod_s3;
	logic signed [DW-1:0]    z_s3;
	logic signed [AW-1:0]    theta_s3;

	assign c1_ctl = c1_side[$bits(ctl_t)-1:0];

	always_comb begin
		case (c1_ctl.view)
			VIEW_FRONT: theta = (QUARTER <<< 1) + c1_ang;
			VIEW_LEFT:  theta = QUARTER + c1_ang;
			default:    theta = (QUARTER + (QUARTER <<< 1)) - c1_ang;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s3 <= c1_valid;
		end
	end

	// magnitude stays non-negative after vectoring
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3  <= $unsigned(c1_x) * INV_GAIN;
			z_s3     <= c1_side[SW1-1:$bits(ctl_t)];
			theta_s3 <= theta;
			err_s3   <= c1_ctl.err;
		end
	end

	// stage 4: round the corrected magnitude
	localparam logic [DW+GAIN_W-1:0] RND = (DW+GAIN_W)'(1) << (GAIN_W - 1);

	logic                 v_s4, err_s4;
	logic signed [DW-1:0] mag_s4, z_s4;
	logic signed [AW-1:0] theta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s4   <= DW'((prod_s3 + RND) >> GAIN_W);
			z_s4     <= z_s3;
			theta_s4 <= theta_s3;
			err_s4   <= err_s3;
		end
	end

	// second vectoring pass: elevation
	logic                 c2_valid;
	logic signed [DW-1:0] c2_x;
	logic signed [AW-1:0] c2_ang;
	logic [AW:0]          c2_side;

	e2p_cordic #(
		.DW (DW),
		.AB (ANGLE_BITS),
		.AW (AW),
		.N  (CORDIC_STAGES),
		.SW (AW + 1)
	) u_cordic_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (v_s4),
		.in_x      (mag_s4),
		.in_y      (z_s4),
		.in_side   ({theta_s4, err_s4}),
		.out_valid (c2_valid),
		.out_x     (c2_x),
		.out_ang   (c2_ang),
		.out_side  (c2_side)
	);

	// final magnitude is not needed; fold it into nothing but keep the rail observable
	logic unused_mag;
	assign unused_mag = ^c2_x;

	// scale to panorama indices, last stage is the output register
	logic [11:0] src_row;
	logic [12:0] src_col;
	logic        range_error;

	e2p_scale #(
		.AB (ANGLE_BITS),
		.AW (AW)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.in_valid    (c2_valid),
		.a2          (c2_ang),
		.theta       (signed'(c2_side[AW:1])),
		.err         (c2_side[0] | (unused_mag & 1'b0)),
		.pano_w      (pano_w_q),
		.pano_h      (pano_h_q),
		.out_valid   (out_valid),
		.src_row     (src_row),
		.src_col     (src_col),
		.range_error (range_error)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {7'd0, src_col, src_row};
	assign m_tuser  = range_error;

endmodule

// ===== rtl/core/e2p_cordic.sv =====
module e2p_cordic #(
	parameter int DW = 26,
	parameter int AB = 20,
	parameter int AW = AB + 2,
	parameter int N  = 20,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [DW-1:0] in_x,
	input  logic signed [DW-1:0] in_y,
	input  logic        [SW-1:0] in_side,
	output logic                 out_valid,
	output logic signed [DW-1:0] out_x,
	output logic signed [AW-1:0] out_ang,
	output logic        [SW-1:0] out_side
);
	import e2p_pkg::*;

	logic signed [DW-1:0] x_s    [N+1];
	logic signed [DW-1:0] y_s    [N+1];
	logic signed [AW-1:0] a_s    [N+1];
	logic        [SW-1:0] side_s [N+1];
	logic                 v_s    [N+1];

	assign x_s[0]    = in_x;
	assign y_s[0]    = in_y;
	assign a_s[0]    = '0;
	assign side_s[0] = in_side;
	assign v_s[0]    = in_valid;

	for (genvar gi = 0; gi < N; gi++) begin : g_stage
		localparam logic signed [AW-1:0] STEP = signed'(AW'(table_angle(gi, AB)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi+1] <= 1'b0;
			end else if (en) begin
				v_s[gi+1] <= v_s[gi];
			end
		end

		// one micro-rotation, shifts floor toward minus infinity
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[gi+1] <= side_s[gi];
				if (!y_s[gi][DW-1]) begin
					x_s[gi+1] <= x_s[gi] + (y_s[gi] >>> gi);
					y_s[gi+1] <= y_s[gi] - (x_s[gi] >>> gi);
					a_s[gi+1] <= a_s[gi] + STEP;
				end else begin
					x_s[gi+1] <= x_s[gi] - (y_s[gi] >>> gi);
					y_s[gi+1] <= y_s[gi] + (x_s[gi] >>> gi);
					a_s[gi+1] <= a_s[gi] - STEP;
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_x     = x_s[N];
	assign out_ang   = a_s[N];
	assign out_side  = side_s[N];

endmodule

// ===== rtl/core/e2p_scale.sv =====
module e2p_scale #(
	parameter int AB = 20,
	parameter int AW = AB + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [AW-1:0] a2,
	input  logic signed [AW-1:0] theta,
	input  logic                 err,
	input  logic        [13:0]   pano_w,
	input  logic        [12:0]   pano_h,
	output logic                 out_valid,
	output logic        [11:0]   src_row,
	output logic        [12:0]   src_col,
	output logic                 range_error
);
	import e2p_pkg::*;

	localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (AB - 2);

	logic signed [AW-1:0] phi;
	logic [AB+13:0]       hp_s1;
	logic [AB+14:0]       wp_s1;
	logic                 hpos_s1, wpos_s1, err_s1, v_s1;
	logic [AB+13:0]       hv;
	logic [AB+14:0]       wv;
	logic [11:0]          hlim;
	logic [12:0]          wlim;

	assign phi = QUARTER - a2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	// angle times panorama size
	always_ff @(posedge clk) begin
		if (en) begin
			hp_s1   <= phi[AB:0] * pano_h;
			wp_s1   <= theta[AB:0] * pano_w;
			hpos_s1 <= !phi[AW-1] && (phi != '0);
			wpos_s1 <= !theta[AW-1] && (theta != '0);
			err_s1  <= err;
		end
	end

	always_comb begin
		hv   = hp_s1 >> (AB - 1);
		wv   = wp_s1 >> AB;
		hlim = (pano_h == '0) ? 12'd0 : (pano_h > 13'd4096) ? 12'd4095 : 12'(pano_h - 13'd1);
		wlim = (pano_w == '0) ? 13'd0 : (pano_w > 14'd8192) ? 13'd8191 : 13'(pano_w - 14'd1);
	end

	// truncate, clamp, zero on error or on a non-positive angle
	always_ff @(posedge clk) begin
		if (en) begin
			range_error <= err_s1;
			if (err_s1 || !hpos_s1) begin
				src_row <= '0;
			end else if (hv > (AB+14)'(hlim)) begin
				src_row <= hlim;
			end else begin
				src_row <= hv[11:0];
			end
			if (err_s1 || !wpos_s1) begin
				src_col <= '0;
			end else if (wv > (AB+15)'(wlim)) begin
				src_col <= wlim;
			end else begin
				src_col <= wv[12:0];
			end
		end
	end

endmodule

// ===== rtl/core/e2p_checker.sv =====
`include "equirect_to_perspective_remap_core_assert.svh"

module e2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// stalled result holds
	`E2P_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// out-of-view results carry zero addresses
	`E2P_ASSERT(a_err_zero, m_tvalid && m_tuser |-> m_tdata[24:0] == 25'd0)

	// input side follows the output slot
	`E2P_ASSERT(a_ready_link, s_tready == (!m_tvalid || m_tready))

	// config port never waits
	`E2P_ASSERT_NORST(a_pready, pready)

endmodule

bind equirect_to_perspective_remap_core e2p_checker u_e2p_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
	import e2p_pkg::*;

	localparam int ABITS   = ANGLE_BITS_DEF;
	localparam int NSTAGE  = CORDIC_STAGES_DEF;
	localparam int LATENCY = 2 * NSTAGE + 6;
	localparam int N_PHASE = 6;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [11:0] row;
		logic [12:0] col;
		logic        err;
	} src_addr_t;

	typedef struct {
		view_t       cmd;
		int          col;
		int          row;
		bit          known;
		src_addr_t   res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // out_col[14:0], out_row[27:15], zero pad
	logic [1:0]  s_tuser = '0;  // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // src_row[11:0], src_col[24:12], zero pad
	logic        m_tuser;       // range_error

	// shadow copy of the register file
	logic [13:0] pano_w = 14'd2048;
	logic [12:0] pano_h = 13'd1024;
	logic [13:0] view_w = 14'd3000;
	logic [13:0] view_h = 14'd3000;
	logic [20:0] focal  = 21'd384000;

	src_addr_t pending_addrs[$];
	src_addr_t typed_addrs[$];
	bit        typed_flags[$];
	int        fail_count = 0;
	bit        hold_req = 1'b0;

	equirect_to_perspective_remap_core i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// safety net against a hung pipeline
	initial begin
		#6000000;
		$display("status: fail");
		$finish;
	end

	// one cordic vectoring pass; returns the angle in turns, gain-scaled magnitude in mag
	function automatic longint cordic_atan2(inout longint mag, input longint yv);
		longint xa, ya, ang, dx, dy, step;
		xa  = mag;
		ya  = yv;
		ang = 0;
		for (int i = 0; i < NSTAGE; i++) begin
			dx   = ya >>> i;
			dy   = xa >>> i;
			// table entry rounded to the angle width
			step = longint'(({32'd0, ATAN_TURN[i]} + (64'd1 << (31 - ABITS))) >> (32 - ABITS));
			if (ya >= 0) begin
				xa += dx; ya -= dy; ang += step;
			end else begin
				xa -= dx; ya += dy; ang -= step;
			end
		end
		mag = xa;
		return ang;
	endfunction

	// angle to pixel index, clamped to the panorama
	function automatic longint angle_to_index(longint ang, longint size, int sh, longint cap);
		longint lim, v;
		if (size == 0) return 0;
		lim = (size - 1 > cap) ? cap : size - 1;
		if (ang <= 0) return 0;
		v = (ang * size) >>> sh;
		return (v > lim) ? lim : v;
	endfunction

	// expected source address for one output pixel
	function automatic src_addr_t map_pixel(logic [1:0] cmd, logic [14:0] col_in,
			logic [12:0] row_in);
		src_addr_t r;
		longint    col, w, x, z, mag, a1, a2, theta, phi, qt;
		int        v;
		col = col_in;
		w   = view_w;
		qt  = longint'(1) << (ABITS - 2);
		if (cmd == VIEW_STRIP) begin
			if (col < w) v = VIEW_LEFT;
			else if (col < 2 * w) begin v = VIEW_FRONT; col -= w; end
			else if (col < 3 * w) begin v = VIEW_RIGHT; col -= 2 * w; end
			else v = -1;
		end else begin
			v = (col < w) ? int'(cmd) : -1;
		end
		r = '0;
		if (v < 0) begin
			r.err = 1'b1;
			return r;
		end
		x   = (col - (w >>> 1)) * 256;
		z   = ((longint'(view_h) >>> 1) - longint'(row_in)) * 256;
		mag = focal;
		a1  = cordic_atan2(mag, x);
		mag = (mag * longint'(INV_GAIN) + (longint'(1) << 29)) >>> 30;
		a2  = cordic_atan2(mag, z);
		case (v)
			VIEW_FRONT: theta = 2 * qt + a1;
			VIEW_LEFT:  theta = qt + a1;
			default:    theta = 3 * qt - a1;
		endcase
		phi   = qt - a2;
		r.row = 12'(angle_to_index(phi, pano_h, ABITS - 1, 4095));
		r.col = 13'(angle_to_index(theta, pano_w, ABITS, 8191));
		return r;
	endfunction

	// accepted input transactions feed the predictor, results are checked in order
	always @(posedge clk) begin
		src_addr_t want, got;
		if (s_tvalid && s_tready) begin
			want = map_pixel(s_tuser, s_tdata[14:0], s_tdata[27:15]);
			// a row of the directed table may carry its answer typed in
			if (typed_flags.size() > 0) begin
				if (typed_flags.pop_front()) want = typed_addrs.pop_front();
			end
			pending_addrs.push_back(want);
		end
		if (m_tvalid && m_tready) begin
			got.row = m_tdata[11:0];
			got.col = m_tdata[24:12];
			got.err = m_tuser;
			if (pending_addrs.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d err %0d",
					$time, got.row, got.col, got.err);
				fail_count++;
			end else begin
				want = pending_addrs.pop_front();
				if (got.row !== want.row) begin
					$display("%0t: src_row expected %0d actual %0d", $time, want.row, got.row);
					fail_count++;
				end
				if (got.col !== want.col) begin
					$display("%0t: src_col expected %0d actual %0d", $time, want.col, got.col);
					fail_count++;
				end
				if (got.err !== want.err) begin
					$display("%0t: range_error expected %0d actual %0d",
						$time, want.err, got.err);
					fail_count++;
				end
			end
		end
	end

	// receiver: random backpressure per result, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// one input transaction, preceded by a random idle gap; called at a falling edge
	task automatic send_pixel(view_t cmd, int col, int row, int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {4'd0, 13'(row), 15'(col)};
		s_tuser  <= cmd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PANO_W: pano_w = val[13:0];
			REG_PANO_H: pano_h = val[12:0];
			REG_OUT_W:  view_w = val[13:0];
			REG_OUT_H:  view_h = val[13:0];
			default:    focal  = val[20:0];
		endcase
	endtask

	// let the pipeline empty before touching the registers
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (pending_addrs.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic load_view(int pw, int ph, int ow, int oh, int fl);
		reg_write(REG_PANO_W, pw);
		reg_write(REG_PANO_H, ph);
		reg_write(REG_OUT_W, ow);
		reg_write(REG_OUT_H, oh);
		reg_write(REG_FOCAL, fl);
	endtask

	initial begin
		dir_row_t dir_rows[$];
		dir_row_t d;
		view_t    cmd;
		int       col, row, w3;

		// directed rows at reset settings (view 3000 x 3000)
		dir_rows = '{
			'{VIEW_FRONT, 1500, 1500, 1'b0, '0},
			'{VIEW_FRONT, 0, 0, 1'b0, '0},
			'{VIEW_FRONT, 2999, 2999, 1'b0, '0},
			'{VIEW_FRONT, 3000, 0, 1'b1, '{12'd0, 13'd0, 1'b1}},
			'{VIEW_LEFT, 0, 1500, 1'b0, '0},
			'{VIEW_LEFT, 2999, 0, 1'b0, '0},
			'{VIEW_LEFT, 32767, 8191, 1'b1, '{12'd0, 13'd0, 1'b1}},
			'{VIEW_RIGHT, 0, 2999, 1'b0, '0},
			'{VIEW_RIGHT, 2999, 1500, 1'b0, '0},
			'{VIEW_RIGHT, 4096, 5, 1'b1, '{12'd0, 13'd0, 1'b1}},
			'{VIEW_STRIP, 0, 0, 1'b0, '0},
			'{VIEW_STRIP, 2999, 1500, 1'b0, '0},
			'{VIEW_STRIP, 3000, 1500, 1'b0, '0},
			'{VIEW_STRIP, 5999, 2999, 1'b0, '0},
			'{VIEW_STRIP, 6000, 1500, 1'b0, '0},
			'{VIEW_STRIP, 8999, 0, 1'b0, '0},
			'{VIEW_STRIP, 9000, 1500, 1'b1, '{12'd0, 13'd0, 1'b1}},
			'{VIEW_STRIP, 24575, 8191, 1'b1, '{12'd0, 13'd0, 1'b1}},
			// row far below the view: z goes strongly negative
			'{VIEW_FRONT, 1500, 8191, 1'b0, '0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			d = dir_rows[k];
			typed_flags.push_back(d.known);
			if (d.known) typed_addrs.push_back(d.res);
			send_pixel(d.cmd, d.col, d.row, 2);
		end
		drain_pipe();

		for (int ph = 0; ph < N_PHASE; ph++) begin
			case (ph)
				// extremes: smallest panorama and view, zero focal length
				0: load_view(1, 1, 2, 2, 0);
				// full-range panorama, 8192 x 8192 view, longest focal length
				1: load_view(8192, 4096, 8192, 8192, 2097151);
				// odd view size, truncated half sizes
				2: load_view(4000, 2000, 101, 77, 25600);
				// view too wide for all columns to be in range in strip mode
				3: load_view(8191, 4095, 16382, 40, 1000);
				default: load_view($urandom_range(1, 8192), $urandom_range(1, 4096),
					2 * $urandom_range(1, 600), 2 * $urandom_range(1, 600),
					$urandom_range(0, 2097151));
			endcase
			w3 = 3 * view_w;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				cmd = view_t'($urandom_range(0, 3));
				if ($urandom_range(0, 9) == 0) begin
					// noise across the full field widths
					col = $urandom_range(0, 32767);
					row = $urandom_range(0, 8191);
				end else begin
					col = $urandom_range(0, (cmd == VIEW_STRIP) ? w3 - 1 : view_w - 1);
					if (col > 32767) col = $urandom_range(16384, 32767);
					row = $urandom_range(0, (view_h > 8192) ? 8191 : view_h - 1);
				end
				// long output hold-off, which stalls the input as well
				if (ph == 4 && n == 20) hold_req = 1'b1;
				send_pixel(cmd, col, row, (n % 50 < 10) ? 0 : 14);
			end
			drain_pipe();
		end

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
